// ===== design/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants, register codes and helpers for the rail transposition
// cipher block.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // letter store depth and derived widths
  localparam int MAX_LETTERS = 64;
  localparam int ADDR_W      = $clog2(MAX_LETTERS);
  localparam int CNT_W       = $clog2(MAX_LETTERS + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int RAIL_W = 7;
  localparam int SUM_W  = RAIL_W + 1;

  // configuration register indexes
  localparam logic REG_RAIL_COUNT   = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  // register reset values
  localparam logic [RAIL_W-1:0] RAIL_RESET = RAIL_W'(2);

  // ascii letter bounds
  localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return ((b >= UPPER_A) && (b <= UPPER_Z)) || ((b >= LOWER_A) && (b <= LOWER_Z));
  endfunction

endpackage

// ===== design/rtc_in_if.sv =====
// ----------------------------------------------------------------------------
// rtc_in_if
// Message byte channel: valid/ready handshake carrying one byte per beat.
// ----------------------------------------------------------------------------
interface rtc_in_if
  import rtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== design/rtc_out_if.sv =====
// ----------------------------------------------------------------------------
// rtc_out_if
// Result channel: valid/ready handshake carrying one transposed letter per
// beat.
// ----------------------------------------------------------------------------
interface rtc_out_if
  import rtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_letter;
  logic              last_letter;
  logic              overflowed;

  modport source (output valid, output out_letter, output last_letter,
                  output overflowed, input ready);
  modport sink   (input valid, input out_letter, input last_letter,
                  input overflowed, output ready);
endinterface

// ===== design/rail_transposition_cipher.sv =====
// On the end-of-message beat the permute pass runs, one store read per letter
// paced by the shared index adder, then the write drain state, then each output
// letter passes a buffer read and a beat, which holds until the receiver is
// ready. Throughput: 1 byte per cycle while loading. Reset clears the letter
// count, the overflow flag and the registers (rail_count 2, decrypt_mode 0);
// the letter buffers are not cleared.
// ----------------------------------------------------------------------------
// rail_transposition_cipher
// Buffers ascii letters and emits them rail permuted (encrypt) or
// un-permuted (decrypt) after the end-of-message beat.
// ----------------------------------------------------------------------------
module rail_transposition_cipher
  import rtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rtc_in_if.sink      in_ch,
  rtc_out_if.source   out_ch
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PERM  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_SHOW  = 3'd4;

  logic [2:0]        state;
  logic [RAIL_W-1:0] rail_count;
  logic              decrypt_mode;
  logic [CNT_W-1:0]  letter_count;
  logic              overflow_flag;

  // run registers
  logic [CNT_W-1:0]  run_len;
  logic              run_ovf;
  logic [RAIL_W-1:0] run_rails;
  logic              run_dec;
  logic [CNT_W-1:0]  row;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  out_idx;

  // memories and their pipeline
  logic [BYTE_W-1:0] letter_store [MAX_LETTERS];
  logic [BYTE_W-1:0] perm_store   [MAX_LETTERS];
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_pending;
  logic [BYTE_W-1:0] out_letter;
  logic              out_last;
  logic              out_valid;

  logic              in_beat;
  logic              letter_hit;
  logic              store_ok;
  logic [CNT_W-1:0]  count_after;
  logic [SUM_W-1:0]  step_sum;
  logic [CNT_W-1:0]  row_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] perm_addr;
  logic              cfg_wr;

  // input decode
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign letter_hit  = is_letter(in_ch.in_byte);
  assign store_ok    = letter_hit && (letter_count < CNT_W'(MAX_LETTERS));
  assign count_after = letter_count + CNT_W'(store_ok);

  // shared index unit: step down a rail, or restart at the next row
  assign step_sum  = SUM_W'(idx) + SUM_W'(run_rails);
  assign row_next  = row + CNT_W'(1);
  assign rd_addr   = run_dec ? pos[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign perm_addr = run_dec ? idx[ADDR_W-1:0] : pos[ADDR_W-1:0];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_RAIL_COUNT:   prdata = {{(32-RAIL_W){1'b0}}, rail_count};
      REG_DECRYPT_MODE: prdata = {31'b0, decrypt_mode};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count   <= RAIL_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RAIL_COUNT:   rail_count   <= pwdata[RAIL_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.out_letter  = out_letter;
  assign out_ch.last_letter = out_last;
  assign out_ch.overflowed  = run_ovf;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      letter_count  <= '0;
      overflow_flag <= 1'b0;
      wr_pending    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      wr_pending <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_ch.end_of_message) begin
              letter_count  <= '0;
              overflow_flag <= 1'b0;
              if (count_after != '0) state <= ST_PERM;
            end else begin
              letter_count <= count_after;
              if (letter_hit && !store_ok) overflow_flag <= 1'b1;
            end
          end
        end
        ST_PERM: begin
          wr_pending <= 1'b1;
          if (pos == run_len - CNT_W'(1)) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_RD;
        ST_RD: begin
          out_valid <= 1'b1;
          state     <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state     <= out_last ? ST_IDLE : ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // run datapath and buffers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_beat) begin
      if (store_ok) letter_store[letter_count[ADDR_W-1:0]] <= in_ch.in_byte;
      run_len   <= count_after;
      run_ovf   <= overflow_flag || (letter_hit && !store_ok);
      run_rails <= (rail_count == '0) ? RAIL_W'(1) : rail_count;
      run_dec   <= decrypt_mode;
      row       <= '0;
      idx       <= '0;
      pos       <= '0;
      out_idx   <= '0;
    end
    if (state == ST_PERM) begin
      rd_data <= letter_store[rd_addr];
      wr_addr <= perm_addr;
      pos     <= pos + CNT_W'(1);
      if (step_sum < SUM_W'(run_len)) begin
        idx <= step_sum[CNT_W-1:0];
      end else begin
        row <= row_next;
        idx <= row_next;
      end
    end
    if (wr_pending) perm_store[wr_addr] <= rd_data;
    if (state == ST_RD) begin
      out_letter <= perm_store[out_idx[ADDR_W-1:0]];
      out_last   <= (out_idx == run_len - CNT_W'(1));
    end
    if (state == ST_SHOW && out_ch.ready) out_idx <= out_idx + CNT_W'(1);
  end

endmodule

// ===== design/rtc_checker.sv =====
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks for the rail transposition cipher, bound to its top.
// ----------------------------------------------------------------------------
module rtc_checker
  import rtc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_letter,
  input logic              out_last,
  input logic              out_ovf
);

  // input side closed while results are pending
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a result is offered");

  // finishing the run reopens the input side
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_ready && out_last) |=> in_ready)
    else $error("input not ready after the last letter");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=>
                   (out_valid && $stable(out_letter) && $stable(out_last) && $stable(out_ovf)))
    else $error("stalled result changed");

  // config port never waits
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind rail_transposition_cipher rtc_checker u_rtc_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_letter(out_ch.out_letter),
  .out_last  (out_ch.last_letter),
  .out_ovf   (out_ch.overflowed)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rail transposition cipher. Message bytes go in over the
// input channel and the permuted letters are checked, beat by beat, against
// a predictor of the letter store and its column-wise rail permutation. A
// short directed table covers letter bounds, empty and single-letter messages
// and the rail count extremes. Random messages follow, under a range of rail
// settings in both modes, with random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
  import rtc_pkg::*;
;

  localparam logic [2:0] RAIL_ADDR   = {REG_RAIL_COUNT, 2'b00};
  localparam logic [2:0] DECRYPT_ADDR = {REG_DECRYPT_MODE, 2'b00};
  localparam int SETTLE_CYCLES  = 4 * MAX_LETTERS + 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 24;
  localparam int NUM_DIRECTED   = 31;
  localparam int NUM_SETTINGS   = 9;

  // one output beat as the receiver sees it
  typedef struct packed {
    logic [BYTE_W-1:0] letter;
    logic              last;
    logic              ovf;
  } cipher_beat_t;

  // one row of the directed table: a register write or a byte beat
  typedef struct {
    bit                cfg;
    logic [2:0]        addr;
    logic [31:0]       wdata;
    logic [BYTE_W-1:0] in_byte;
    bit                eom;
    bit                typed;
    string             cipher_text;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rtc_in_if  in_ch ();
  rtc_out_if out_ch ();

  rail_transposition_cipher u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // predictor copy of the block state
  logic [BYTE_W-1:0] held_letters [MAX_LETTERS];
  int                held_count    = 0;
  bit                held_overflow = 1'b0;
  logic [RAIL_W-1:0] rails_reg     = RAIL_RESET;
  bit                decrypt_reg   = 1'b0;

  cipher_beat_t expected_letters [$];
  cipher_beat_t oldest_beat;

  int  errors          = 0;
  int  letters_checked = 0;
  int  messages        = 0;
  int  overflow_msgs   = 0;
  bit  no_idle         = 1'b0;
  bit  hold_request    = 1'b0;
  int  hold_left       = 0;

  // rail count / mode pairs for the random phases, extremes included
  logic [RAIL_W-1:0] phase_rails [NUM_SETTINGS] = '{1, 3, 64, 127, 5, 7, 0, 64, 2};
  bit                phase_mode  [NUM_SETTINGS] = '{0, 1, 0, 1, 0, 1, 1, 1, 1};

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // letter bounds and their neighbours, rails 2, encrypt
    '{0, 3'd0, 32'd0, 8'h41, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h40, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h5A, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h5B, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h61, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h60, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h7A, 1, 1, "AaZz"},
    // empty message gives no letters
    '{0, 3'd0, 32'd0, 8'h00, 1, 1, ""},
    // non-letters dropped, end byte itself kept
    '{0, 3'd0, 32'd0, 8'hFF, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h7B, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h71, 1, 1, "q"},
    // ragged last column
    '{0, 3'd0, 32'd0, 8'h61, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h62, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h63, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h64, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h65, 1, 1, "acebd"},
    // decrypt undoes the first message
    '{1, DECRYPT_ADDR, 32'd1, 8'h00, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h41, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h61, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h5A, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h7A, 1, 1, "AZaz"},
    // zero rails acts as one
    '{1, RAIL_ADDR, 32'd0, 8'h00, 0, 0, ""},
    '{1, DECRYPT_ADDR, 32'd0, 8'h00, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h78, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h79, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h7A, 1, 1, "xyz"},
    // more rails than letters
    '{1, RAIL_ADDR, 32'd127, 8'h00, 0, 0, ""},
    '{1, DECRYPT_ADDR, 32'd1, 8'h00, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h48, 0, 0, ""},
    '{0, 3'd0, 32'd0, 8'h69, 1, 1, "Hi"},
    '{0, 3'd0, 32'd0, 8'h21, 1, 1, ""}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // letter store and rail permutation, one accepted byte beat at a time
  function automatic void rail_predict(input logic [BYTE_W-1:0] b, input logic e,
                                       output cipher_beat_t beats [$]);
    logic [BYTE_W-1:0] perm [MAX_LETTERS];
    int n;
    int r;
    int p;
    beats = {};
    if ((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z)) begin
      if (held_count < MAX_LETTERS) begin
        held_letters[held_count] = b;
        held_count++;
      end else begin
        held_overflow = 1'b1;
      end
    end
    if (!e) return;
    n = held_count;
    r = (rails_reg == 0) ? 1 : int'(rails_reg);
    p = 0;
    // walk the grid row by row; letter i sits in row i mod r
    for (int row = 0; row < r && row < n; row++) begin
      for (int i = row; i < n; i += r) begin
        if (decrypt_reg) perm[i] = held_letters[p];
        else perm[p] = held_letters[i];
        p++;
      end
    end
    for (int i = 0; i < n; i++) beats.push_back('{perm[i], i == n - 1, held_overflow});
    messages++;
    if (held_overflow && n > 0) overflow_msgs++;
    held_count    = 0;
    held_overflow = 1'b0;
  endfunction

  // offer one byte beat, with random idle gaps, and predict on acceptance
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic e, input bit typed = 1'b0);
    cipher_beat_t fresh [$];
    if (!no_idle && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= b;
    in_ch.end_of_message <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rail_predict(b, e, fresh);
    if (!typed) foreach (fresh[k]) expected_letters.push_back(fresh[k]);
  endtask

  // drop valid, let every expected letter arrive, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access cycle, then the bus returns to idle
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == RAIL_ADDR) rails_reg = data[RAIL_W-1:0];
    else if (addr == DECRYPT_ADDR) decrypt_reg = data[0];
    @(posedge clk);
  endtask

  // one short random message: mostly letters, some arbitrary bytes
  task automatic send_message(output int sent);
    int len;
    logic [BYTE_W-1:0] b;
    len  = $urandom_range(1, 6);
    sent = len;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 3) == 0) b = BYTE_W'($urandom_range(0, 255));
      else b = ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + BYTE_W'($urandom_range(0, 25));
      send_beat(b, k == len - 1);
    end
  endtask

  // receiver ready: random stalls, long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // compare each output beat with the oldest expected letter
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_letters.size() == 0) begin
        $error("out_letter: expected nothing, actual %h", out_ch.out_letter);
        errors++;
      end else begin
        oldest_beat = expected_letters.pop_front();
        letters_checked++;
        if (out_ch.out_letter !== oldest_beat.letter) begin
          $error("out_letter: expected %h, actual %h", oldest_beat.letter, out_ch.out_letter);
          errors++;
        end
        if (out_ch.last_letter !== oldest_beat.last) begin
          $error("last_letter: expected %b, actual %b", oldest_beat.last, out_ch.last_letter);
          errors++;
        end
        if (out_ch.overflowed !== oldest_beat.ovf) begin
          $error("overflowed: expected %b, actual %b", oldest_beat.ovf, out_ch.overflowed);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int random_items;
    int got;
    string txt;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.in_byte        <= '0;
    in_ch.end_of_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      if (directed_rows[k].cfg) begin
        wait_idle();
        reg_write(directed_rows[k].addr, directed_rows[k].wdata);
      end else begin
        send_beat(directed_rows[k].in_byte, directed_rows[k].eom, directed_rows[k].typed);
        if (directed_rows[k].typed) begin
          txt = directed_rows[k].cipher_text;
          for (int c = 0; c < txt.len(); c++)
            expected_letters.push_back('{txt[c], c == txt.len() - 1, 1'b0});
        end
      end
    end

    // random messages, one rail setting per message
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase < NUM_SETTINGS) begin
        reg_write(RAIL_ADDR, 32'(phase_rails[phase]));
        reg_write(DECRYPT_ADDR, 32'(phase_mode[phase]));
      end else begin
        reg_write(RAIL_ADDR, 32'($urandom_range(0, 127)));
        reg_write(DECRYPT_ADDR, 32'($urandom_range(0, 1)));
      end
      // one phase runs flat out on both sides
      no_idle = (phase == 4);
      send_message(got);
      random_items += got;
      phase++;
    end

    // receiver holds off while a full store and a second message queue up;
    // the sender and, once released, the receiver run with no idling
    wait_idle();
    no_idle = 1'b0;
    reg_write(RAIL_ADDR, 32'd4);
    reg_write(DECRYPT_ADDR, 32'd0);
    no_idle      = 1'b1;
    hold_request = 1'b1;
    for (int k = 0; k < MAX_LETTERS + 1; k++)
      send_beat(LOWER_A + BYTE_W'($urandom_range(0, 25)), k == MAX_LETTERS);
    send_message(got);

    wait_idle();
    no_idle = 1'b0;
    $display("covered %0d messages (%0d overflowing), %0d letters checked", messages,
             overflow_msgs, letters_checked);
    $display("rail counts 0 to 127 in both modes, with a long receiver hold-off");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
